@@ hdl/vlq_enc_pkg.sv @@
`default_nettype none

package vlq_enc_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int WORD_BITS   = 64;
    localparam int GROUP_BITS  = 7;
    localparam int BYTE_BITS   = 8;
    localparam int GROUP_COUNT = (WORD_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int EXT_BITS    = GROUP_COUNT * GROUP_BITS;
    localparam int IDX_W       = $clog2(GROUP_COUNT);

    localparam logic [BYTE_BITS-1:0] PREFIX_POS = 8'h80;
    localparam logic [BYTE_BITS-1:0] PREFIX_NEG = 8'hFF;

    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_PREFIX,
        ST_EMIT
    } vlq_state_t;

    typedef struct packed {
        logic load;
        logic find;
        logic emit_prefix;
        logic emit_group;
    } vlq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic prefix_needed;
        logic idx_zero;
    } vlq_stat_t;

endpackage

`default_nettype wire

@@ hdl/vlq_enc_dp.sv @@
`default_nettype none

module vlq_enc_dp
    import vlq_enc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vlq_cmd_t              cmd,
    output vlq_stat_t                  stat,
    input  wire logic                  command,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [BYTE_BITS-1:0]       code_byte,
    output logic                       last_byte
);

    logic [EXT_BITS-1:0]   word_reg, word_next;
    logic                  neg_reg, neg_next;
    logic                  signed_reg, signed_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]  code_reg, code_next;
    logic                  last_reg, last_next;

    logic                  load_neg;
    logic [EXT_BITS-1:0]   ext_word;
    logic [GROUP_BITS-1:0] grp [GROUP_COUNT];
    logic [IDX_W-1:0]      top_idx;
    logic [GROUP_BITS-1:0] top_grp;
    logic [GROUP_BITS-1:0] cur_grp;
    logic                  idx_zero;
    logic                  out_free;

    assign load_neg = (command == CMD_SIGNED) && value[WORD_BITS-1];
    assign ext_word = EXT_BITS'($signed({load_neg, value[WORD_BITS-1:0]}));

    always_comb
    begin
        for (int k = 0; k < GROUP_COUNT; k++)
        begin
            grp[k] = word_reg[k*GROUP_BITS +: GROUP_BITS];
        end
    end

    // highest group that is not a copy of the sign
    always_comb
    begin
        top_idx = '0;
        for (int k = 0; k < GROUP_COUNT; k++)
        begin
            if (grp[k] != {GROUP_BITS{neg_reg}})
            begin
                top_idx = IDX_W'(k);
            end
        end
    end

    assign top_grp  = grp[top_idx];
    assign cur_grp  = grp[idx_reg];
    assign idx_zero = (idx_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.out_free      = out_free;
    assign stat.prefix_needed = signed_reg && (top_grp[GROUP_BITS-1] != neg_reg);
    assign stat.idx_zero      = idx_zero;

    always_comb
    begin
        word_next   = word_reg;
        neg_next    = neg_reg;
        signed_next = signed_reg;
        idx_next    = idx_reg;
        if (cmd.load)
        begin
            word_next   = ext_word;
            neg_next    = load_neg;
            signed_next = (command == CMD_SIGNED);
        end
        if (cmd.find)
        begin
            idx_next = top_idx;
        end
        else if (cmd.emit_group && !idx_zero)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_comb
    begin
        code_next      = code_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.emit_prefix)
        begin
            code_next      = neg_reg ? PREFIX_NEG : PREFIX_POS;
            last_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (cmd.emit_group)
        begin
            code_next      = {!idx_zero, cur_grp};
            last_next      = idx_zero;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        neg_reg    <= neg_next;
        signed_reg <= signed_next;
        idx_reg    <= idx_next;
        code_reg   <= code_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign code_byte = code_reg;
    assign last_byte = last_reg;

    a_last_no_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_prefix || cmd.emit_group) |=> (last_reg != code_reg[BYTE_BITS-1]))
        else $error("continuation flag disagrees with last byte");

    a_top_significant: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find |=> (idx_reg == '0) || (grp[idx_reg] != {GROUP_BITS{neg_reg}}))
        else $error("top kept group is a sign copy");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_prefix || cmd.emit_group) |-> out_free)
        else $error("byte written over a waiting byte");

endmodule

`default_nettype wire

@@ hdl/vlq_enc_ctrl.sv @@
`default_nettype none

module vlq_enc_ctrl
    import vlq_enc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire vlq_stat_t stat,
    output vlq_cmd_t       cmd
);

    vlq_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                state_next = stat.prefix_needed ? ST_PREFIX : ST_EMIT;
            end
            ST_PREFIX:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free && stat.idx_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_FIND:
            begin
                cmd.find = 1'b1;
            end
            ST_PREFIX:
            begin
                cmd.emit_prefix = stat.out_free;
            end
            ST_EMIT:
            begin
                cmd.emit_group = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_find: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_FIND))
        else $error("accepted word not followed by group search");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_group && stat.idx_zero) |=> in_ready)
        else $error("not ready after last byte of a word");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.find, cmd.emit_prefix, cmd.emit_group}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

@@ hdl/vlq_integer_encoder_core.sv @@
// Big-endian base-128 encoder: each 64-bit word becomes 1 to 10 bytes, seven bits per
// byte, most significant group first, bit 7 set on all but the last byte (last_byte
// marks it). command 0 encodes unsigned, 1 two's complement; signed words get a 0x80
// or 0xFF lead byte when the top kept group's bit 6 disagrees with the sign. A word is
// accepted, the top group that is not a sign copy is found, then bytes go out one per
// cycle while the output is free, through the group counter into the single output
// register. The next word is accepted while the last byte of the previous one still
// waits on the output.
`default_nettype none

module vlq_integer_encoder_core
    import vlq_enc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  command,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [BYTE_BITS-1:0]       code_byte,
    output logic                       last_byte
);

    vlq_cmd_t  cmd;
    vlq_stat_t stat;

    vlq_enc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vlq_enc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code_byte (code_byte),
        .last_byte (last_byte)
    );

endmodule

`default_nettype wire
